/* rtl/core/f2i_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// f2i_pkg: shared types and constants
// Rounding mode codes and field constants for the float to int64 converter.
// ----------------------------------------------------------------------------
package f2i_pkg;

	typedef enum logic [1:0] {
		RM_NEAREST = 2'd0,
		RM_ZERO    = 2'd1,
		RM_PINF    = 2'd2,
		RM_MINF    = 2'd3
	} round_mode_t;

	localparam logic [7:0]  EXP_BIAS       = 8'h7f;
	localparam logic [7:0]  EXP_ALL_ONES   = 8'hff;
	localparam logic [31:0] NEG_TWO63_BITS = 32'hdf000000;
	localparam logic [63:0] INT64_MIN      = 64'h8000000000000000;
	localparam logic [1:0]  REG_ROUND_MODE = 2'd0;

endpackage

/* rtl/core/f2i_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// f2i_in_if / f2i_out_if: item channels
// Valid/ready channels carrying the input word and the conversion result.
// ----------------------------------------------------------------------------
interface f2i_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] float_bits;
	modport source (output valid, output float_bits, input ready);
	modport sink   (input valid, input float_bits, output ready);
endinterface

interface f2i_out_if;
	logic               valid;
	logic               ready;
	logic signed [63:0] int_value;
	logic               invalid_flag;
	logic               inexact_flag;
	modport source (output valid, output int_value, output invalid_flag,
		output inexact_flag, input ready);
	modport sink   (input valid, input int_value, input invalid_flag,
		input inexact_flag, output ready);
endinterface

/* rtl/core/float32_to_int64_round.sv */
`timescale 1ns / 1ps
// Path: an accepted input passes the s1, s2, s3 and s4 registers before its result is offered.
// Throughput: one item per cycle; the pipeline advances whenever the output
// register is empty or being taken, so a stall freezes all stages together.
// Reset: arst_n clears all valid bits and sets round_mode to nearest even.
// ----------------------------------------------------------------------------
// float32_to_int64_round: IEEE single to signed 64-bit integer conversion
// Four-stage pipeline: unpack, shift, round, negate and output.
// ----------------------------------------------------------------------------
module float32_to_int64_round (
	input  logic        clk,
	input  logic        arst_n,
	f2i_in_if.sink      in_ch,
	f2i_out_if.source   out_ch,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	// Configuration register; one register at byte address 0.
	f2i_pkg::round_mode_t round_mode_q;
	assign pready = 1'b1;
	assign prdata = {30'd0, round_mode_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			round_mode_q <= f2i_pkg::RM_NEAREST;
		end else if (psel && penable && pwrite && paddr == f2i_pkg::REG_ROUND_MODE) begin
			round_mode_q <= f2i_pkg::round_mode_t'(pwdata[1:0]);
		end
	end

	// The whole pipe moves as one when the output slot can take a new item.
	logic adv;
	logic v_s1, v_s2, v_s3, v_s4;
	assign adv = !v_s4 || out_ch.ready;
	assign in_ch.ready = adv;

	// Stage 1: unpack. sig is the 24-bit significand; exp_u is the unbiased
	// exponent plus 127 (so e >= 23 means exp_u >= 150).
	logic        neg_s1, spec_s1, big_s1, exact_s1;
	logic [23:0] sig_s1;
	logic [5:0]  sh_s1;   // left shift for exact values, right shift otherwise
	logic [7:0]  ef;
	logic [8:0]  eu;

	always_comb begin
		ef = in_ch.float_bits[30:23];
		eu = (ef == 8'd0) ? 9'd1 : {1'b0, ef};
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			neg_s1   <= in_ch.float_bits[31];
			sig_s1   <= {(ef != 8'd0), in_ch.float_bits[22:0]};
			spec_s1  <= (ef == f2i_pkg::EXP_ALL_ONES);
			big_s1   <= (eu >= 9'd190) && (ef != f2i_pkg::EXP_ALL_ONES)
				&& (in_ch.float_bits != f2i_pkg::NEG_TWO63_BITS);
			exact_s1 <= (eu >= 9'd150);
			if (eu >= 9'd150)
				sh_s1 <= 6'((eu - 9'd150) & 9'h3f);
			else if (eu <= 9'd110)
				sh_s1 <= 6'd40;
			else
				sh_s1 <= 6'(9'd150 - eu);
		end
	end

	// Stage 2: shift. Right shifts keep a 40-bit fraction field below the point.
	logic        neg_s2, spec_s2, big_s2;
	logic [63:0] mag_s2;
	logic [39:0] rem_s2;
	logic [39:0] half_s2;
	logic [63:0] wide_r;

	always_comb begin
		wide_r = {sig_s1, 40'd0} >> sh_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			neg_s2  <= neg_s1;
			spec_s2 <= spec_s1;
			big_s2  <= big_s1;
			if (exact_s1) begin
				mag_s2  <= {40'd0, sig_s1} << sh_s1;
				rem_s2  <= 40'd0;
			end else begin
				mag_s2  <= {40'd0, wide_r[63:40]};
				rem_s2  <= wide_r[39:0];
			end
			half_s2 <= 40'h8000000000;
		end
	end

	// Stage 3: round decision and increment.
	logic        neg_s3, spec_s3, big_s3, inx_s3;
	logic [63:0] mag_s3;
	logic        up;

	always_comb begin
		case (round_mode_q)
			f2i_pkg::RM_NEAREST: up = (rem_s2 > half_s2)
				|| (rem_s2 == half_s2 && mag_s2[0]);
			f2i_pkg::RM_ZERO:    up = 1'b0;
			f2i_pkg::RM_PINF:    up = (rem_s2 != 40'd0) && !neg_s2;
			f2i_pkg::RM_MINF:    up = (rem_s2 != 40'd0) && neg_s2;
			default:             up = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			neg_s3  <= neg_s2;
			spec_s3 <= spec_s2;
			big_s3  <= big_s2;
			inx_s3  <= (rem_s2 != 40'd0);
			mag_s3  <= mag_s2 + {63'd0, up};
		end
	end

	// Stage 4: negate, substitute the invalid result, hold for the consumer.
	logic [63:0] res_s4;
	logic        inv_s4, inx_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			if (spec_s3 || big_s3) begin
				res_s4 <= f2i_pkg::INT64_MIN;
				inv_s4 <= 1'b1;
				inx_s4 <= 1'b0;
			end else begin
				res_s4 <= neg_s3 ? (64'd0 - mag_s3) : mag_s3;
				inv_s4 <= 1'b0;
				inx_s4 <= inx_s3;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_ch.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	assign out_ch.valid        = v_s4;
	assign out_ch.int_value    = res_s4;
	assign out_ch.invalid_flag = inv_s4;
	assign out_ch.inexact_flag = inx_s4;

`ifndef NO_ASSERTIONS
	a_inv_value: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && inv_s4 |-> res_s4 == f2i_pkg::INT64_MIN && !inx_s4)
		else $error("invalid result without most negative value");
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && !out_ch.ready |=> v_s4 && $stable(res_s4))
		else $error("stalled result changed");
	a_pipe_move: assert property (@(posedge clk) disable iff (!arst_n)
		adv && v_s3 |=> v_s4)
		else $error("item lost between stages");
`endif

endmodule
